### hdl/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; the using scope supplies clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CPD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/cpd_pkg.sv
// Shared types, codes and the CRC-16 table function for the frame receiver.
// Depends on nothing.
package cpd_pkg;

  localparam int unsigned MAX_PAYLOAD = 256;
  localparam int unsigned CNT_W =
    ($clog2(MAX_PAYLOAD + 1) > 9) ? $clog2(MAX_PAYLOAD + 1) : 9;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH   = 1'd1;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  localparam logic [1:0] ST_GOOD      = 2'd0;
  localparam logic [1:0] ST_CRC_BAD   = 2'd1;
  localparam logic [1:0] ST_TOO_LONG  = 2'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [8:0]  LEN_SAT  = 9'h1FF;

  typedef struct packed {
    logic [1:0] item_kind;
    logic [7:0] frame_type;
    logic [8:0] payload_length;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [1:0] status;
    logic       last;
  } cpd_item_t;

  // Request from the frame control to the CRC unit.
  typedef struct packed {
    logic       feed;
    logic       clear;
    logic [7:0] data;
  } cpd_crc_req_t;

  // Status back from the CRC unit.
  typedef struct packed {
    logic        ready;
    logic [15:0] crc;
  } cpd_crc_sts_t;

  // One table entry: eight shift steps of the MSB-first CRC on (idx << 8).
  function automatic logic [15:0] cpd_crc_entry(input logic [7:0] idx);
    logic [15:0] c;
    c = {idx, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hdl/cpd_byte_if.sv
// Receive-byte channel: valid/ready handshake carrying one serial byte.
// Depends on nothing.
interface cpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### hdl/cpd_item_if.sv
// Result channel: valid/ready handshake carrying one frame item.
// Depends on nothing.
interface cpd_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic [7:0] frame_type;
  logic [8:0] payload_length;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output item_kind, output frame_type,
                  output payload_length, output data_byte, output byte_index,
                  output status, output last, input ready);
  modport sink   (input valid, input item_kind, input frame_type,
                  input payload_length, input data_byte, input byte_index,
                  input status, input last, output ready);
endinterface

### hdl/cpd_crc_unit.sv
// CRC-16 engine: 256-entry table memory filled after reset, running CRC.
// Depends on cpd_pkg.
module cpd_crc_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cpd_pkg::cpd_crc_req_t req_i,
  output cpd_pkg::cpd_crc_sts_t sts_o
);
  import cpd_pkg::*;

  logic [15:0] tab_mem [256];
  logic [15:0] rd_q;
  logic [8:0]  fill_q;
  logic        pend_q;
  logic [15:0] crc_q;

  // Fill port during the sweep; lookup read every cycle.
  always_ff @(posedge clk_i) begin
    if (!fill_q[8]) begin
      tab_mem[fill_q[7:0]] <= cpd_crc_entry(fill_q[7:0]);
    end
    rd_q <= tab_mem[crc_q[15:8] ^ req_i.data];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pend_q <= 1'b0;
      crc_q  <= CRC_INIT;
    end else begin
      if (!fill_q[8]) begin
        fill_q <= fill_q + 9'd1;
      end
      if (req_i.clear) begin
        crc_q <= CRC_INIT;
      end else if (pend_q) begin
        crc_q <= {crc_q[7:0], 8'h00} ^ rd_q;
      end
      pend_q <= req_i.feed;
    end
  end

  assign sts_o.ready = fill_q[8] & ~pend_q;
  assign sts_o.crc   = crc_q;

endmodule

### hdl/cpd_frame_ctl.sv
// Frame parser: phase sequencer, header fields, config and output buffer.
// Depends on cpd_pkg and the CRC unit status.
module cpd_frame_ctl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cpd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cpd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cpd_pkg::cpd_item_t            out_item_o,
  input  cpd_pkg::cpd_crc_sts_t         crc_sts_i,
  output cpd_pkg::cpd_crc_req_t         crc_req_o
);
  import cpd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT, PH_TYPE, PH_LEN_LO, PH_LEN_HI, PH_DATA, PH_CRC_LO, PH_CRC_HI
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [7:0]       type_q, type_d;
  logic [15:0]      len_q, len_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       crc_lo_q, crc_lo_d;
  logic [7:0]       marker_q;
  logic [8:0]       max_len_q;

  cpd_item_t main_q, main_d, skid_q, skid_d, new_item;
  logic      main_v_q, main_v_d, skid_v_q, skid_v_d;
  logic      push, pop, accept;

  logic [15:0]      len_full, limit, max_len_ext;
  logic [CNT_W-1:0] cnt_inc;
  logic             too_long;

  assign in_ready_o = crc_sts_i.ready & ~skid_v_q;
  assign accept     = in_valid_i & in_ready_o;
  assign pop        = main_v_q & out_ready_i;

  assign len_full    = {in_byte_i, len_q[7:0]};
  assign max_len_ext = 16'(max_len_q);
  assign limit       = (max_len_ext < 16'(MAX_PAYLOAD)) ? max_len_ext : 16'(MAX_PAYLOAD);
  assign too_long    = len_full > limit;
  assign cnt_inc     = cnt_q + CNT_W'(1);

  always_comb begin
    phase_d  = phase_q;
    type_d   = type_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    crc_lo_d = crc_lo_q;
    push     = 1'b0;
    crc_req_o.feed  = 1'b0;
    crc_req_o.clear = 1'b0;
    crc_req_o.data  = in_byte_i;
    new_item.item_kind      = KIND_HEADER;
    new_item.frame_type     = type_q;
    new_item.payload_length = len_q[8:0];
    new_item.data_byte      = '0;
    new_item.byte_index     = '0;
    new_item.status         = ST_GOOD;
    new_item.last           = 1'b0;
    if (accept) begin
      case (phase_q)
        PH_TYPE: begin
          type_d         = in_byte_i;
          crc_req_o.feed = 1'b1;
          phase_d        = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_d          = {8'h00, in_byte_i};
          crc_req_o.feed = 1'b1;
          phase_d        = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_d = len_full;
          push  = 1'b1;
          if (too_long) begin
            crc_req_o.clear         = 1'b1;
            new_item.item_kind      = KIND_STATUS;
            new_item.payload_length = (len_full > 16'(LEN_SAT)) ? LEN_SAT : len_full[8:0];
            new_item.status         = ST_TOO_LONG;
            new_item.last           = 1'b1;
            phase_d                 = PH_HUNT;
          end else begin
            crc_req_o.feed          = 1'b1;
            cnt_d                   = '0;
            new_item.payload_length = len_full[8:0];
            phase_d                 = (len_full == 16'd0) ? PH_CRC_LO : PH_DATA;
          end
        end
        PH_DATA: begin
          crc_req_o.feed      = 1'b1;
          push                = 1'b1;
          new_item.item_kind  = KIND_PAYLOAD;
          new_item.data_byte  = in_byte_i;
          new_item.byte_index = cnt_q[7:0];
          cnt_d               = cnt_inc;
          if (16'(cnt_inc) >= len_q) begin
            phase_d = PH_CRC_LO;
          end
        end
        PH_CRC_LO: begin
          crc_lo_d = in_byte_i;
          phase_d  = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          push               = 1'b1;
          crc_req_o.clear    = 1'b1;
          new_item.item_kind = KIND_STATUS;
          new_item.status    = ({in_byte_i, crc_lo_q} == crc_sts_i.crc) ? ST_GOOD : ST_CRC_BAD;
          new_item.last      = 1'b1;
          phase_d            = PH_HUNT;
        end
        default: begin
          // Hunting: drop everything but the start marker.
          phase_d = PH_HUNT;
          if (in_byte_i == marker_q) begin
            crc_req_o.clear = 1'b1;
            len_d           = '0;
            cnt_d           = '0;
            phase_d         = PH_TYPE;
          end
        end
      endcase
    end
  end

  // Two-entry output buffer: main register plus skid.
  always_comb begin
    main_d   = main_q;
    skid_d   = skid_q;
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    if (!main_v_q || pop) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        main_v_d = 1'b1;
        skid_d   = new_item;
        skid_v_d = push;
      end else begin
        main_d   = new_item;
        main_v_d = push;
      end
    end else if (push) begin
      skid_d   = new_item;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      type_q    <= '0;
      len_q     <= '0;
      cnt_q     <= '0;
      crc_lo_q  <= '0;
      marker_q  <= '0;
      max_len_q <= 9'(MAX_PAYLOAD);
      main_v_q  <= 1'b0;
      skid_v_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      type_q   <= type_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      crc_lo_q <= crc_lo_d;
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_START_MARKER: marker_q  <= cfg_data_i[7:0];
          REG_MAX_LENGTH:   max_len_q <= cfg_data_i[8:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = main_v_q;
  assign out_item_o  = main_q;

endmodule

### hdl/crc_packet_deframer_unit.sv
// Top level of the length-prefixed frame receiver with CRC-16 check.
// Depends on cpd_pkg, cpd_byte_if, cpd_item_if, cpd_crc_unit, cpd_frame_ctl.
//
// Takes received serial bytes one word at a time and hunts for the start
// marker, dropping every other byte while hunting. A frame is marker, type,
// 16-bit little-endian length, payload, 16-bit little-endian CRC-16/CCITT-FALSE
// (poly 0x1021, init 0xFFFF) over type, length and payload. Out come a header
// word, one word per payload byte and a final status word (last = 1): good,
// CRC mismatch, or length too large (the latter right after the header bytes,
// in place of the header). Consumers drop the payload of a bad frame.
// Start-up: after reset the block fills its 256-entry CRC table memory and
// holds in ready low meanwhile; configuration writes are taken at any time.
// Afterwards a byte that enters the CRC (type, length, payload) holds in ready
// low until its registered table read has updated the running CRC; the start
// marker, hunted bytes and CRC bytes do not. Results sit in a two-word output
// buffer, so input keeps flowing while one result waits.
// Configuration: write start_marker at index 0 and max_length at index 1,
// only while the block is idle. The effective length limit is the smaller of
// max_length and the built-in payload maximum.
module crc_packet_deframer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cpd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cpd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  cpd_byte_if.sink                       in_if,
  cpd_item_if.source                     out_if
);
  import cpd_pkg::*;

  cpd_crc_req_t crc_req;
  cpd_crc_sts_t crc_sts;
  cpd_item_t    out_item;

  // Table memory and running CRC.
  cpd_crc_unit u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (crc_req),
    .sts_o  (crc_sts)
  );

  // Phase sequencer, header fields and result buffer.
  cpd_frame_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .in_byte_i   (in_if.rx_byte),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_item_o  (out_item),
    .crc_sts_i   (crc_sts),
    .crc_req_o   (crc_req)
  );

  // Spread the result word onto the channel fields.
  assign out_if.item_kind      = out_item.item_kind;
  assign out_if.frame_type     = out_item.frame_type;
  assign out_if.payload_length = out_item.payload_length;
  assign out_if.data_byte      = out_item.data_byte;
  assign out_if.byte_index     = out_item.byte_index;
  assign out_if.status         = out_item.status;
  assign out_if.last           = out_item.last;

endmodule

### hdl/cpd_checker.sv
// Port-level checks on the frame receiver, bound onto the top level.
// Depends on cpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cpd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] item_kind,
  input logic [8:0] payload_length,
  input logic [7:0] byte_index,
  input logic [1:0] status,
  input logic       last
);
  import cpd_pkg::*;

  `CPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `CPD_ASSERT_IMPL(a_last_kind, out_valid, last == (item_kind == KIND_STATUS), "last flag mismatch")
  `CPD_ASSERT_IMPL(a_status_only_end, out_valid && (item_kind != KIND_STATUS), status == ST_GOOD, "status on non-final word")
  `CPD_ASSERT_IMPL(a_index_range, out_valid && (item_kind == KIND_PAYLOAD), 9'(byte_index) < payload_length, "payload index past length")

endmodule

bind crc_packet_deframer_unit cpd_checker u_cpd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .item_kind      (out_if.item_kind),
  .payload_length (out_if.payload_length),
  .byte_index     (out_if.byte_index),
  .status         (out_if.status),
  .last           (out_if.last)
);

### dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for crc_packet_deframer_unit: feeds received bytes, predicts the
// header, payload and status words of every frame and checks them in order.
// Depends on cpd_pkg, cpd_byte_if, cpd_item_if and the unit under test.
module tb_top;
  import cpd_pkg::*;

  localparam int unsigned CLK_PERIOD  = 8;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned TIMEOUT_NS  = 2_000_000;
  // Quiet cycles after the last word; covers the registered CRC step and the
  // two-word output buffer with margin.
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned MAX_REPORTS = 40;
  localparam int unsigned HOLD_OFF_CYCLES = 300;

  // Receive phases of the frame predictor.
  typedef enum logic [2:0] {
    RX_HUNT, RX_TYPE, RX_LEN_LO, RX_LEN_HI, RX_DATA, RX_CRC_LO, RX_CRC_HI
  } rx_phase_e;

  // Where a directed row takes its byte from: the row itself, or the running
  // CRC of the frame so far (optionally corrupted).
  typedef enum logic [1:0] {
    SRC_BYTE, SRC_CRC_LO, SRC_CRC_HI, SRC_CRC_LO_BAD
  } byte_src_e;

  typedef struct {
    logic [7:0] rx_byte;
    byte_src_e  src;
    bit         fixed;   // 1: the row carries its own expected word
    cpd_item_t  want;
  } dir_row_t;

  localparam cpd_item_t NO_WORD = '0;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  cpd_byte_if in_ch ();
  cpd_item_if out_ch ();

  crc_packet_deframer_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Frame predictor state and its copy of the configuration registers.
  logic [7:0]  marker_cfg = 8'h00;
  logic [8:0]  maxlen_cfg = 9'd256;
  rx_phase_e   rx_phase   = RX_HUNT;
  logic [15:0] run_crc    = CRC_INIT;
  logic [7:0]  cur_type   = 8'h00;
  logic [15:0] cur_len    = 16'h0000;
  logic [15:0] pay_cnt    = 16'h0000;
  logic [7:0]  crc_lo_rx  = 8'h00;

  cpd_item_t   pending_words[$];   // expected words, oldest first
  int unsigned err_count      = 0;
  int unsigned word_cnt       = 0; // bytes the block does not simply drop
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;

  dir_row_t dir_tab [23];

  // MSB-first CRC-16 step over one byte, polynomial from the package.
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int          i;
    c = crc ^ {b, 8'h00};
    for (i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Effective payload limit: the smaller of the register and the built-in max.
  function automatic int unsigned len_limit();
    return (maxlen_cfg < MAX_PAYLOAD) ? maxlen_cfg : MAX_PAYLOAD;
  endfunction

  // Advance the frame predictor by one received byte; return 1 with the word
  // the block must emit for it, if any.
  function automatic bit deframe_byte(input logic [7:0] b, output cpd_item_t w);
    w = NO_WORD;
    deframe_byte = 1'b0;
    case (rx_phase)
      RX_TYPE: begin
        cur_type = b;
        run_crc  = crc16_next(run_crc, b);
        rx_phase = RX_LEN_LO;
      end
      RX_LEN_LO: begin
        cur_len  = {8'h00, b};
        run_crc  = crc16_next(run_crc, b);
        rx_phase = RX_LEN_HI;
      end
      RX_LEN_HI: begin
        cur_len[15:8] = b;
        run_crc       = crc16_next(run_crc, b);
        w.frame_type  = cur_type;
        if (cur_len > len_limit()) begin
          // Abort at once: status word in place of the header.
          w.item_kind      = KIND_STATUS;
          w.payload_length = (cur_len > LEN_SAT) ? LEN_SAT : cur_len[8:0];
          w.status         = ST_TOO_LONG;
          w.last           = 1'b1;
          rx_phase         = RX_HUNT;
          run_crc          = CRC_INIT;
        end else begin
          w.item_kind      = KIND_HEADER;
          w.payload_length = cur_len[8:0];
          pay_cnt          = 16'h0000;
          if (cur_len == 16'h0000) begin
            rx_phase = RX_CRC_LO;
          end else begin
            rx_phase = RX_DATA;
          end
        end
        deframe_byte = 1'b1;
      end
      RX_DATA: begin
        run_crc          = crc16_next(run_crc, b);
        w.item_kind      = KIND_PAYLOAD;
        w.frame_type     = cur_type;
        w.payload_length = cur_len[8:0];
        w.data_byte      = b;
        w.byte_index     = pay_cnt[7:0];
        pay_cnt          = pay_cnt + 16'd1;
        if (pay_cnt >= cur_len) begin
          rx_phase = RX_CRC_LO;
        end
        deframe_byte = 1'b1;
      end
      RX_CRC_LO: begin
        crc_lo_rx = b;
        rx_phase  = RX_CRC_HI;
      end
      RX_CRC_HI: begin
        w.item_kind      = KIND_STATUS;
        w.frame_type     = cur_type;
        w.payload_length = cur_len[8:0];
        w.status         = ({b, crc_lo_rx} == run_crc) ? ST_GOOD : ST_CRC_BAD;
        w.last           = 1'b1;
        rx_phase         = RX_HUNT;
        run_crc          = CRC_INIT;
        deframe_byte     = 1'b1;
      end
      default: begin
        // Hunting: drop everything but the start marker.
        if (b == marker_cfg) begin
          run_crc  = CRC_INIT;
          cur_len  = 16'h0000;
          pay_cnt  = 16'h0000;
          rx_phase = RX_TYPE;
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (err_count < MAX_REPORTS) begin
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
    end
    err_count++;
  endtask

  // Compare one accepted output word with the oldest pending expectation.
  task automatic check_word(input cpd_item_t got);
    cpd_item_t want;
    if (pending_words.size() == 0) begin
      report_mismatch("word with nothing pending, item_kind", got.item_kind, 16'h0);
    end else begin
      want = pending_words.pop_front();
      if (got.item_kind !== want.item_kind)
        report_mismatch("item_kind", got.item_kind, want.item_kind);
      if (got.frame_type !== want.frame_type)
        report_mismatch("frame_type", got.frame_type, want.frame_type);
      if (got.payload_length !== want.payload_length)
        report_mismatch("payload_length", got.payload_length, want.payload_length);
      if (got.data_byte !== want.data_byte)
        report_mismatch("data_byte", got.data_byte, want.data_byte);
      if (got.byte_index !== want.byte_index)
        report_mismatch("byte_index", got.byte_index, want.byte_index);
      if (got.status !== want.status)
        report_mismatch("status", got.status, want.status);
      if (got.last !== want.last)
        report_mismatch("last", got.last, want.last);
    end
  endtask

  // Offer one byte, hold it until the block takes it, then predict. A fixed
  // row supplies its own expected word instead of the predicted one.
  task automatic send_word(input logic [7:0] b, input bit fixed, input cpd_item_t want);
    cpd_item_t w;
    bit        has_word;
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    if (!(rx_phase == RX_HUNT && b != marker_cfg)) begin
      word_cnt++;
    end
    has_word = deframe_byte(b, w);
    if (fixed) begin
      pending_words.push_back(want);
    end else if (has_word) begin
      pending_words.push_back(w);
    end
    // Random sender gap after the handshake.
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Drop valid and wait for every expected word, then let the block settle.
  task automatic drain_outputs();
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers back to back; only called with the block idle.
  task automatic write_config(input logic [7:0] marker, input logic [8:0] max_len);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_START_MARKER;
    cfg_data_i <= CFG_DATA_W'(marker);
    @(posedge clk_i);
    cfg_idx_i  <= REG_MAX_LENGTH;
    cfg_data_i <= max_len;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    marker_cfg = marker;
    maxlen_cfg = max_len;
  endtask

  // One frame with random content, optionally preceded by line noise. A
  // broken frame is cut short in the payload and then fed random bytes until
  // the predictor is back to hunting. forced_len < 0 picks a random length.
  task automatic send_frame(input bit broken, input int forced_len);
    logic [7:0]  b;
    logic [15:0] len;
    logic [15:0] mask;
    int unsigned lim;
    int unsigned npay;
    int unsigned r;
    int unsigned k;
    lim = len_limit();
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom);
        if (b == marker_cfg) b = ~b;
        send_word(b, 1'b0, NO_WORD);
      end
    end
    send_word(marker_cfg, 1'b0, NO_WORD);
    send_word(8'($urandom), 1'b0, NO_WORD);
    r = $urandom_range(99);
    if (forced_len >= 0) begin
      len = 16'(forced_len);
    end else if (r < 70) begin
      len = 16'($urandom_range((lim < 8) ? lim : 8));
    end else if (r < 80) begin
      len = (lim <= 24) ? 16'(lim) : 16'($urandom_range(24));
    end else if (r < 92) begin
      len = 16'(lim + 1 + $urandom_range(15));
    end else begin
      len = 16'($urandom);
    end
    send_word(len[7:0], 1'b0, NO_WORD);
    send_word(len[15:8], 1'b0, NO_WORD);
    if (len > lim) return;
    npay = broken ? $urandom_range(len) : len;
    for (k = 0; k < npay; k++) begin
      // Put the marker value into the payload now and then.
      send_word(($urandom_range(9) == 0) ? marker_cfg : 8'($urandom), 1'b0, NO_WORD);
    end
    if (broken) begin
      while (rx_phase != RX_HUNT) send_word(8'($urandom), 1'b0, NO_WORD);
      return;
    end
    mask = ($urandom_range(99) < 85) ? 16'h0000 : 16'($urandom_range(1, 65535));
    send_word(run_crc[7:0] ^ mask[7:0], 1'b0, NO_WORD);
    send_word(run_crc[15:8] ^ mask[15:8], 1'b0, NO_WORD);
  endtask

  task automatic run_frames(input int unsigned target);
    int unsigned start;
    start = word_cnt;
    while (word_cnt - start < target) send_frame($urandom_range(19) == 0, -1);
  endtask

  // Output side: sample every accepted word and check it.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      check_word('{out_ch.item_kind, out_ch.frame_type, out_ch.payload_length,
                   out_ch.data_byte, out_ch.byte_index, out_ch.status, out_ch.last});
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [7:0] b;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_START_MARKER;
    cfg_data_i    <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;

    // Directed frames under the reset configuration (marker 0x00, limit 256).
    dir_tab = '{
      // noise while hunting is dropped
      '{8'h55, SRC_BYTE, 1'b0, NO_WORD},
      // zero-length frame, type 0xFF, good CRC
      '{8'h00, SRC_BYTE, 1'b0, NO_WORD},
      '{8'hFF, SRC_BYTE, 1'b0, NO_WORD},
      '{8'h00, SRC_BYTE, 1'b0, NO_WORD},
      '{8'h00, SRC_BYTE, 1'b1, '{KIND_HEADER, 8'hFF, 9'd0, 8'd0, 8'd0, ST_GOOD, 1'b0}},
      '{8'h00, SRC_CRC_LO, 1'b0, NO_WORD},
      '{8'h00, SRC_CRC_HI, 1'b1, '{KIND_STATUS, 8'hFF, 9'd0, 8'd0, 8'd0, ST_GOOD, 1'b1}},
      // length one above the limit aborts
      '{8'h00, SRC_BYTE, 1'b0, NO_WORD},
      '{8'h12, SRC_BYTE, 1'b0, NO_WORD},
      '{8'h01, SRC_BYTE, 1'b0, NO_WORD},
      '{8'h01, SRC_BYTE, 1'b1, '{KIND_STATUS, 8'h12, 9'd257, 8'd0, 8'd0, ST_TOO_LONG, 1'b1}},
      // largest length saturates the reported length
      '{8'h00, SRC_BYTE, 1'b0, NO_WORD},
      '{8'h00, SRC_BYTE, 1'b0, NO_WORD},
      '{8'hFF, SRC_BYTE, 1'b0, NO_WORD},
      '{8'hFF, SRC_BYTE, 1'b1, '{KIND_STATUS, 8'h00, LEN_SAT, 8'd0, 8'd0, ST_TOO_LONG, 1'b1}},
      // two payload bytes, the first equal to the marker, bad CRC
      '{8'h00, SRC_BYTE, 1'b0, NO_WORD},
      '{8'h7E, SRC_BYTE, 1'b0, NO_WORD},
      '{8'h02, SRC_BYTE, 1'b0, NO_WORD},
      '{8'h00, SRC_BYTE, 1'b1, '{KIND_HEADER, 8'h7E, 9'd2, 8'd0, 8'd0, ST_GOOD, 1'b0}},
      '{8'h00, SRC_BYTE, 1'b1, '{KIND_PAYLOAD, 8'h7E, 9'd2, 8'h00, 8'd0, ST_GOOD, 1'b0}},
      '{8'hFF, SRC_BYTE, 1'b1, '{KIND_PAYLOAD, 8'h7E, 9'd2, 8'hFF, 8'd1, ST_GOOD, 1'b0}},
      '{8'h00, SRC_CRC_LO_BAD, 1'b0, NO_WORD},
      '{8'h00, SRC_CRC_HI, 1'b1, '{KIND_STATUS, 8'h7E, 9'd2, 8'd0, 8'd0, ST_CRC_BAD, 1'b1}}
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The block fills its CRC table first; the handshake absorbs that.
    foreach (dir_tab[i]) begin
      case (dir_tab[i].src)
        SRC_CRC_LO:     b = run_crc[7:0];
        SRC_CRC_HI:     b = run_crc[15:8];
        SRC_CRC_LO_BAD: b = run_crc[7:0] ^ 8'h01;
        default:        b = dir_tab[i].rx_byte;
      endcase
      send_word(b, dir_tab[i].fixed, dir_tab[i].want);
    end
    drain_outputs();

    // Full rate on both sides.
    write_config(8'hA5, 9'd256);
    run_frames(60);
    drain_outputs();

    // Zero-length limit, sender mostly idle; all-ones marker.
    write_config(8'hFF, 9'd0);
    send_idle_pct = 66;
    run_frames(30);
    drain_outputs();

    // Small limit, receiver mostly stalled; open with a long hold-off so the
    // output buffer fills and the block pushes back on its input.
    write_config(8'h3C, 9'd17);
    send_idle_pct  = 0;
    recv_stall_pct = 66;
    hold_left     <= HOLD_OFF_CYCLES;
    run_frames(60);
    drain_outputs();

    // Register above the built-in max; one frame of the largest payload.
    write_config(8'($urandom), 9'h1FF);
    send_idle_pct  = 17;
    recv_stall_pct = 17;
    send_frame(1'b0, MAX_PAYLOAD);
    run_frames(20);
    drain_outputs();

    // One-byte limit, back to full rate.
    write_config(8'h00, 9'd1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_frames(30);
    drain_outputs();

    if (err_count == 0 && pending_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
